### rtl/core/wsp_pkg.sv
// shared types and constants of the world-to-screen projection block
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

  // operation codes of an input transaction
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_e;

  localparam int REG_W   = 15;  // viewport register width
  localparam int CLIP_W  = 50;  // clip coordinate, signed Q16.16 with headroom
  localparam int DIV_D_W = 49;  // positive clip w as an unsigned divisor
  localparam int QUO_W   = 40;  // quotient bits produced by the dividers
  localparam int SX_W    = 40;  // screen coordinate width
  localparam int DZ_W    = 32;  // depth width
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // saturation limits on the quotient magnitude
  localparam logic [QUO_W-1:0] SX_POS_LIM = QUO_W'((64'd1 << (SX_W - 1)) - 64'd1);
  localparam logic [QUO_W-1:0] SX_NEG_LIM = QUO_W'(64'd1 << (SX_W - 1));
  localparam logic [QUO_W-1:0] DZ_POS_LIM = QUO_W'((64'd1 << (DZ_W - 1)) - 64'd1);
  localparam logic [QUO_W-1:0] DZ_NEG_LIM = QUO_W'(64'd1 << (DZ_W - 1));

  // clip space point handed from the front to the back
  typedef struct packed {
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] cz;
    logic signed [CLIP_W-1:0] cw;
  } clip_t;

endpackage

`default_nettype wire

### rtl/core/world_to_screen_projection.sv
// top level of the world-to-screen projection block
//
// input channel (in_valid_i / in_stall_o): a load transaction writes one
//   coefficient of the 4x4 view-projection matrix and gives no result; a
//   project transaction carries a world point and gives exactly one result
// output channel (out_valid_o / out_stall_i): visible flag, screen x and y
//   in pixels with 16 fraction bits, and depth with 24 fraction bits
// apb port: screen width at address 0, screen height at address 4
// path from the accepting edge to the output register: two front stages,
//   one queue write, two back stages, 41 divider stages (an overflow check,
//   then one quotient bit per stage) and the output register
// throughput: one transaction per cycle while in_stall_o is low, loads and projects alike
// a four-entry queue separates the matrix front from the divide back, so
//   the front keeps accepting while the back is held by out_stall_i; once
//   the queue fills, in_stall_o rises
// the back pipeline freezes as a whole while a result is stalled
// reset: matrix cleared to zero, width 1920, height 1080, pipelines empty
`timescale 1ns / 1ps
`default_nettype none

module world_to_screen_projection #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // apb configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [3:0]          coef_index_i,
  input  wire logic signed [31:0]  coef_value_i,
  input  wire logic signed [31:0]  world_x_i,
  input  wire logic signed [31:0]  world_y_i,
  input  wire logic signed [31:0]  world_z_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     visible_o,
  output logic signed [39:0]       screen_x_o,
  output logic signed [39:0]       screen_y_o,
  output logic signed [31:0]       depth_ndc_o
);

  logic [wsp_pkg::REG_W-1:0] width_q;
  logic [wsp_pkg::REG_W-1:0] height_q;
  logic                      cfg_wr;

  logic           push;
  logic           push_ready;
  wsp_pkg::clip_t push_data;
  logic           q_valid;
  wsp_pkg::clip_t q_data;
  logic           pop;

  // register write in the access phase; address bit 2 picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wsp_pkg::REG_W'(1920);
      height_q <= wsp_pkg::REG_W'(1080);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        height_q <= pwdata[wsp_pkg::REG_W-1:0];
      end else begin
        width_q <= pwdata[wsp_pkg::REG_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(height_q) : 32'(width_q);

  // front: loads go to the matrix, projects become clip points
  wsp_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .world_x_i    (world_x_i),
    .world_y_i    (world_y_i),
    .world_z_i    (world_z_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  wsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (push_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  // back: scaling, divide, saturation
  wsp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clip_valid_i    (q_valid),
    .clip_i          (q_data),
    .pop_o           (pop),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .visible_o       (visible_o),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .depth_ndc_o     (depth_ndc_o)
  );

endmodule

`default_nettype wire

### rtl/core/wsp_front.sv
// front part: accepts transactions, keeps the matrix, forms clip coordinates
`timescale 1ns / 1ps
`default_nettype none

module wsp_front #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [3:0]          coef_index_i,
  input  wire logic signed [31:0]  coef_value_i,
  input  wire logic signed [31:0]  world_x_i,
  input  wire logic signed [31:0]  world_y_i,
  input  wire logic signed [31:0]  world_z_i,
  output logic                     push_o,
  output wsp_pkg::clip_t           push_data_o,
  input  wire logic                push_ready_i
);

  localparam int ST_W = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;

  logic signed [ST_W-1:0] mat_q [16];
  logic signed [31:0]     coef_ext [16];
  logic signed [31:0]     pt [3];
  logic signed [63:0]     prod [16];
  logic signed [47:0]     term_d [16];
  logic signed [47:0]     s1_term_q [16];
  logic                   s1_valid_q;
  logic                   s2_valid_q;
  wsp_pkg::clip_t         s2_clip_q;
  wsp_pkg::clip_t         clip_d;
  logic                   adv;
  logic                   accept;
  logic                   is_load;

  assign adv        = !s2_valid_q || push_ready_i;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;
  assign is_load    = (wsp_pkg::op_e'(opcode_i) == wsp_pkg::OP_LOAD);

  assign pt[0] = world_x_i;
  assign pt[1] = world_y_i;
  assign pt[2] = world_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
    end else if (accept && is_load) begin
      mat_q[coef_index_i] <= coef_value_i[ST_W-1:0];
    end
  end

  // one product per matrix entry, floored to Q16.16; the w column takes 1.0
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      coef_ext[i] = 32'(mat_q[i]);
      if ((i % 4) == 3) begin
        prod[i]   = '0;
        term_d[i] = 48'(mat_q[i]);
      end else begin
        prod[i]   = coef_ext[i] * pt[i % 4];
        term_d[i] = prod[i][63:16];
      end
    end
  end

  always_comb begin
    clip_d.cx = wsp_pkg::CLIP_W'(s1_term_q[0])  + wsp_pkg::CLIP_W'(s1_term_q[1])
              + wsp_pkg::CLIP_W'(s1_term_q[2])  + wsp_pkg::CLIP_W'(s1_term_q[3]);
    clip_d.cy = wsp_pkg::CLIP_W'(s1_term_q[4])  + wsp_pkg::CLIP_W'(s1_term_q[5])
              + wsp_pkg::CLIP_W'(s1_term_q[6])  + wsp_pkg::CLIP_W'(s1_term_q[7]);
    clip_d.cz = wsp_pkg::CLIP_W'(s1_term_q[8])  + wsp_pkg::CLIP_W'(s1_term_q[9])
              + wsp_pkg::CLIP_W'(s1_term_q[10]) + wsp_pkg::CLIP_W'(s1_term_q[11]);
    clip_d.cw = wsp_pkg::CLIP_W'(s1_term_q[12]) + wsp_pkg::CLIP_W'(s1_term_q[13])
              + wsp_pkg::CLIP_W'(s1_term_q[14]) + wsp_pkg::CLIP_W'(s1_term_q[15]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && !is_load;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 16; i++) begin
        s1_term_q[i] <= term_d[i];
      end
      s2_clip_q <= clip_d;
    end
  end

  assign push_o      = s2_valid_q;
  assign push_data_o = s2_clip_q;

endmodule

`default_nettype wire

### rtl/core/wsp_fifo.sv
// short queue of clip points between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module wsp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wsp_pkg::clip_t       data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output wsp_pkg::clip_t       data_o,
  input  wire logic            pop_i
);

  wsp_pkg::clip_t                mem_q [wsp_pkg::FIFO_DEPTH];
  logic [wsp_pkg::FIFO_AW-1:0]   wr_q;
  logic [wsp_pkg::FIFO_AW-1:0]   rd_q;
  logic [wsp_pkg::FIFO_AW:0]     count_q;
  logic                          do_push;
  logic                          do_pop;

  assign ready_o = (count_q != (wsp_pkg::FIFO_AW + 1)'(wsp_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/wsp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
`default_nettype none

module wsp_div #(
  parameter int N_W = 81
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [N_W-1:0]              num_i,
  input  wire logic [wsp_pkg::DIV_D_W-1:0] den_i,
  output logic [wsp_pkg::QUO_W-1:0]        quo_o,
  output logic                             ovf_o
);

  localparam int K     = wsp_pkg::QUO_W;
  localparam int D_W   = wsp_pkg::DIV_D_W;
  localparam int TOP_W = N_W - K;
  localparam int CMP_W = (TOP_W > D_W) ? TOP_W : D_W;

  logic [D_W-1:0] rem_q [K+1];
  logic [K-1:0]   low_q [K+1];
  logic [D_W-1:0] den_q [K+1];
  logic           ovf_q [K+1];
  logic [TOP_W-1:0] top;

  assign top = num_i[N_W-1:K];

  // first stage: quotient overflows when the top part already reaches the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (CMP_W'(top) >= CMP_W'(den_i));
      rem_q[0] <= D_W'(top);
      low_q[0] <= num_i[K-1:0];
      den_q[0] <= den_i;
    end
  end

  for (genvar j = 1; j <= K; j++) begin : g_stage
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         ge;

    assign trial = {rem_q[j-1], low_q[j-1][K-1]};
    assign diff  = trial - {1'b0, den_q[j-1]};
    assign ge    = (trial >= {1'b0, den_q[j-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        low_q[j] <= {low_q[j-1][K-2:0], ge};
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo_o = low_q[K];
  assign ovf_o = ovf_q[K];

endmodule

`default_nettype wire

### rtl/core/wsp_back.sv
// back part: viewport scaling, perspective divide, saturation, output register
`timescale 1ns / 1ps
`default_nettype none

module wsp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clip_valid_i,
  input  wsp_pkg::clip_t                  clip_i,
  output logic                            pop_o,
  input  wire logic [wsp_pkg::REG_W-1:0]  screen_width_i,
  input  wire logic [wsp_pkg::REG_W-1:0]  screen_height_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            visible_o,
  output logic signed [wsp_pkg::SX_W-1:0] screen_x_o,
  output logic signed [wsp_pkg::SX_W-1:0] screen_y_o,
  output logic signed [wsp_pkg::DZ_W-1:0] depth_ndc_o
);

  localparam int K    = wsp_pkg::QUO_W;
  localparam int CW   = wsp_pkg::CLIP_W;
  localparam int MX_W = CW + 1;
  localparam int PX_W = MX_W + wsp_pkg::REG_W;
  localparam int NX_W = PX_W + 15;
  localparam int NZ_W = CW + 24;

  typedef struct packed {
    logic valid;
    logic vis;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } sb_t;

  logic adv;

  // stage b0: numerators and visibility
  logic signed [MX_W-1:0]       nx, ny;
  logic [MX_W-1:0]              b0_magx_q, b0_magy_q;
  logic [CW-1:0]                b0_magz_q;
  logic [wsp_pkg::DIV_D_W-1:0]  b0_den_q;
  sb_t                          b0_sb_q;
  sb_t                          b0_sb_d;

  // stage b1: viewport scaling
  logic [PX_W-1:0]              b1_px_q, b1_py_q;
  logic [CW-1:0]                b1_magz_q;
  logic [wsp_pkg::DIV_D_W-1:0]  b1_den_q;
  sb_t                          b1_sb_q;

  sb_t                          sb_q [K+1];
  logic [K-1:0]                 qx, qy, qz;
  logic                         ovx, ovy, ovz;
  logic [K-1:0]                 selx, sely, selz;
  logic [K-1:0]                 sx_d, sy_d, dz_d;

  logic                         out_valid_q;
  logic                         vis_q;
  logic signed [wsp_pkg::SX_W-1:0] sx_q, sy_q;
  logic signed [wsp_pkg::DZ_W-1:0] dz_q;

  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = clip_valid_i && adv;

  assign nx = MX_W'(clip_i.cx) + MX_W'(clip_i.cw);
  assign ny = MX_W'(clip_i.cw) - MX_W'(clip_i.cy);

  always_comb begin
    b0_sb_d.valid = pop_o;
    b0_sb_d.vis   = !clip_i.cw[CW-1] && (clip_i.cw != '0)
                    && (screen_width_i != '0) && (screen_height_i != '0);
    b0_sb_d.neg_x = nx[MX_W-1];
    b0_sb_d.neg_y = ny[MX_W-1];
    b0_sb_d.neg_z = clip_i.cz[CW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b0_magx_q <= nx[MX_W-1] ? MX_W'(-nx) : MX_W'(nx);
      b0_magy_q <= ny[MX_W-1] ? MX_W'(-ny) : MX_W'(ny);
      b0_magz_q <= clip_i.cz[CW-1] ? CW'(-clip_i.cz) : CW'(clip_i.cz);
      b0_den_q  <= clip_i.cw[wsp_pkg::DIV_D_W-1:0];
      b1_px_q   <= PX_W'(b0_magx_q) * PX_W'(screen_width_i);
      b1_py_q   <= PX_W'(b0_magy_q) * PX_W'(screen_height_i);
      b1_magz_q <= b0_magz_q;
      b1_den_q  <= b0_den_q;
    end
  end

  wsp_div #(.N_W(NX_W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({b1_px_q, 15'd0}),
    .den_i (b1_den_q),
    .quo_o (qx),
    .ovf_o (ovx)
  );

  wsp_div #(.N_W(NX_W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({b1_py_q, 15'd0}),
    .den_i (b1_den_q),
    .quo_o (qy),
    .ovf_o (ovy)
  );

  wsp_div #(.N_W(NZ_W)) u_div_z (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({b1_magz_q, 24'd0}),
    .den_i (b1_den_q),
    .quo_o (qz),
    .ovf_o (ovz)
  );

  // flags ride alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_sb_q <= '0;
      b1_sb_q <= '0;
      for (int i = 0; i <= K; i++) begin
        sb_q[i] <= '0;
      end
    end else if (adv) begin
      b0_sb_q  <= b0_sb_d;
      b1_sb_q  <= b0_sb_q;
      sb_q[0]  <= b1_sb_q;
      for (int i = 1; i <= K; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // saturate magnitude, then apply sign
  always_comb begin
    if (sb_q[K].neg_x) begin
      selx = (ovx || (qx > wsp_pkg::SX_NEG_LIM)) ? wsp_pkg::SX_NEG_LIM : qx;
      sx_d = -selx;
    end else begin
      selx = (ovx || (qx > wsp_pkg::SX_POS_LIM)) ? wsp_pkg::SX_POS_LIM : qx;
      sx_d = selx;
    end
    if (sb_q[K].neg_y) begin
      sely = (ovy || (qy > wsp_pkg::SX_NEG_LIM)) ? wsp_pkg::SX_NEG_LIM : qy;
      sy_d = -sely;
    end else begin
      sely = (ovy || (qy > wsp_pkg::SX_POS_LIM)) ? wsp_pkg::SX_POS_LIM : qy;
      sy_d = sely;
    end
    if (sb_q[K].neg_z) begin
      selz = (ovz || (qz > wsp_pkg::DZ_NEG_LIM)) ? wsp_pkg::DZ_NEG_LIM : qz;
      dz_d = -selz;
    end else begin
      selz = (ovz || (qz > wsp_pkg::DZ_POS_LIM)) ? wsp_pkg::DZ_POS_LIM : qz;
      dz_d = selz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sb_q[K].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= sb_q[K].vis;
      sx_q  <= sb_q[K].vis ? wsp_pkg::SX_W'(sx_d) : '0;
      sy_q  <= sb_q[K].vis ? wsp_pkg::SX_W'(sy_d) : '0;
      dz_q  <= sb_q[K].vis ? dz_d[wsp_pkg::DZ_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = vis_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign depth_ndc_o = dz_q;

endmodule

`default_nettype wire

### rtl/core/wsp_checker.sv
// port-level assertions for the projection block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module wsp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               pready,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               visible_o,
  input wire logic signed [39:0] screen_x_o,
  input wire logic signed [39:0] screen_y_o,
  input wire logic signed [31:0] depth_ndc_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o)
      && $stable(screen_x_o) && $stable(screen_y_o) && $stable(depth_ndc_o))
    else $error("stalled result changed");

  // an invisible result carries zero coordinates
  a_invisible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0
      && depth_ndc_o == '0)
    else $error("invisible result with nonzero coordinates");

  // configuration never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .visible_o   (visible_o),
  .screen_x_o  (screen_x_o),
  .screen_y_o  (screen_y_o),
  .depth_ndc_o (depth_ndc_o)
);

`default_nettype wire

### verif/tb_world_to_screen_projection.sv
// testbench of the world-to-screen projection block: directed table, random phases, checker
`timescale 1ns / 1ps

module tb_world_to_screen_projection;

  localparam int ITEMS_PER_PHASE = 260;
  localparam int DRAIN_CYCLES    = 60;    // extra wait after the last pending point has come out
  localparam int WATCHDOG_LIMIT  = 3000;  // idle cycles with no transaction at all
  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  // one row of the directed table
  typedef struct {
    wsp_pkg::op_e       op;
    logic [3:0]         idx;
    logic signed [31:0] coef;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    bit                 typed;    // expected result written in the row itself
    logic               vis;
    logic signed [39:0] sx;
    logic signed [39:0] sy;
    logic signed [31:0] dz;
  } dir_row_t;

  // one projected point as seen at the output
  typedef struct {
    logic               vis;
    logic signed [39:0] sx;
    logic signed [39:0] sy;
    logic signed [31:0] dz;
  } screen_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               opcode_i = 1'b0;
  logic [3:0]         coef_index_i = '0;
  logic signed [31:0] coef_value_i = '0;
  logic signed [31:0] world_x_i = '0, world_y_i = '0, world_z_i = '0;

  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               visible_o;
  logic signed [39:0] screen_x_o, screen_y_o;
  logic signed [31:0] depth_ndc_o;

  always #5 clk_i = ~clk_i;

  world_to_screen_projection dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .opcode_i, .coef_index_i, .coef_value_i,
    .world_x_i, .world_y_i, .world_z_i,
    .out_valid_o, .out_stall_i, .visible_o, .screen_x_o, .screen_y_o, .depth_ndc_o
  );

  // predictor state: shadow matrix and viewport registers
  longint     shadow_m[16];
  logic [14:0] view_w, view_h;

  screen_pt_t pending_pts[$];   // expected projections, oldest first
  int mismatches    = 0;
  int points_seen   = 0;
  int hidden_seen   = 0;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  // num * mult / den rounded toward zero, clamped to a signed field of fw bits
  function automatic longint scaled_quot(longint num, longint mult, longint den, int fw);
    logic [127:0] mag, prod, quo, lim;
    bit neg;
    neg  = num < 0;
    mag  = neg ? 128'(-num) : 128'(num);
    prod = mag * 128'(mult);
    quo  = prod / 128'(den);
    lim  = neg ? (128'd1 << (fw - 1)) : ((128'd1 << (fw - 1)) - 128'd1);
    if (quo > lim) quo = lim;
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  // matrix times homogeneous point, divide by w, map to the viewport
  function automatic screen_pt_t project_point(logic signed [31:0] wx,
                                               logic signed [31:0] wy,
                                               logic signed [31:0] wz);
    screen_pt_t res;
    longint pt[4];
    longint clip[4];
    pt[0] = wx; pt[1] = wy; pt[2] = wz; pt[3] = 65536;
    for (int r = 0; r < 4; r++) begin
      clip[r] = 0;
      for (int c = 0; c < 4; c++) clip[r] += (shadow_m[r*4+c] * pt[c]) >>> 16;
    end
    res = '{1'b0, '0, '0, '0};
    if (clip[3] > 0 && view_w != 0 && view_h != 0) begin
      res.vis = 1'b1;
      res.sx  = 40'(scaled_quot(clip[0] + clip[3], longint'(view_w) << 15, clip[3], 40));
      res.sy  = 40'(scaled_quot(clip[3] - clip[1], longint'(view_h) << 15, clip[3], 40));
      res.dz  = 32'(scaled_quot(clip[2], 64'd1 << 24, clip[3], 32));
    end
    return res;
  endfunction

  // drive one transaction and hold it until accepted; valid stays high afterwards
  task automatic offer_item(wsp_pkg::op_e op, logic [3:0] idx, logic signed [31:0] coef,
                            logic signed [31:0] wx, logic signed [31:0] wy,
                            logic signed [31:0] wz);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    coef_index_i <= idx;
    coef_value_i <= coef;
    world_x_i    <= wx;
    world_y_i    <= wy;
    world_z_i    <= wz;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // random gap on the input side, mostly none or short
  task automatic input_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write, setup then access phase
  task automatic apb_write(logic [2:0] addr, logic [14:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {17'($urandom), val};   // upper bits are dropped by the register
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WIDTH) view_w = val; else view_h = val;
  endtask

  // record the effect of an accepted transaction
  task automatic account(wsp_pkg::op_e op, logic [3:0] idx, logic signed [31:0] coef,
                         logic signed [31:0] wx, logic signed [31:0] wy,
                         logic signed [31:0] wz);
    if (op == wsp_pkg::OP_LOAD) shadow_m[idx] = longint'(coef);
    else pending_pts.push_back(project_point(wx, wy, wz));
  endtask

  function automatic logic signed [31:0] rand_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;   // within +/-4.0
  endfunction

  function automatic logic signed [31:0] rand_world();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h8000000)) - 32'sh4000000;  // within +/-1024.0
  endfunction

  // output side: random stall, long hold-off on request, and the checker
  always @(posedge clk_i) begin
    screen_pt_t want;
    int r;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;

      if (out_valid_o && !out_stall_i) begin
        if (pending_pts.size() == 0) begin
          $error("result transaction with no projection pending");
          mismatches++;
        end else begin
          want = pending_pts.pop_front();
          points_seen++;
          if (!want.vis) hidden_seen++;
          if (visible_o !== want.vis) begin
            $error("visible: expected %0d, got %0d", want.vis, visible_o);
            mismatches++;
          end
          if (screen_x_o !== want.sx) begin
            $error("screen_x: expected %0d, got %0d", want.sx, screen_x_o);
            mismatches++;
          end
          if (screen_y_o !== want.sy) begin
            $error("screen_y: expected %0d, got %0d", want.sy, screen_y_o);
            mismatches++;
          end
          if (depth_ndc_o !== want.dz) begin
            $error("depth_ndc: expected %0d, got %0d", want.dz, depth_ndc_o);
            mismatches++;
          end
        end
      end

      // receiver stall pattern
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) out_stall_i <= 1'b0;
        else if (r < 97) out_stall_i <= 1'b1;
        else begin
          out_stall_i <= 1'b1;
          hold_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  dir_row_t dir_rows[$];
  logic [14:0] phase_w[7] = '{15'd1920, 15'd0, 15'd640, 15'd16384, 15'd32767, 15'd1,
                              15'd800};
  logic [14:0] phase_h[7] = '{15'd1080, 15'd1080, 15'd0, 15'd16384, 15'd1, 15'd32767,
                              15'd600};

  initial begin
    screen_pt_t typed_pt;
    dir_row_t row;
    wsp_pkg::op_e op;
    logic [3:0] idx;
    logic signed [31:0] cf, wx, wy, wz;

    for (int i = 0; i < 16; i++) shadow_m[i] = 0;
    view_w = 15'd1920;
    view_h = 15'd1080;

    // directed table; typed rows carry results readable at a glance
    dir_rows = '{
      // all-zero matrix after reset: clip w is zero, so nothing is visible
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
        1, 1'b0, 40'sd0, 40'sd0, 32'sd0},
      '{wsp_pkg::OP_PROJECT, 4'd9, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
        32'sh7fffffff, 1, 1'b0, 40'sd0, 40'sd0, 32'sd0},
      // w = 1.0: the origin lands in the middle of the 1920x1080 viewport
      '{wsp_pkg::OP_LOAD, 4'd15, 32'sh10000, 32'sh7fffffff, 32'sh80000000, 32'sd1,
        0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
        1, 1'b1, 40'sd62914560, 40'sd35389440, 32'sd0},
      '{wsp_pkg::OP_LOAD, 4'd0, 32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd5, 32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd10, 32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sh10000, 32'shffff0000, 32'sh8000,
        0, 0, 0, 0, 0},
      // extreme points: saturation of all three outputs
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
        0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd15, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
        32'sh80000000, 0, 0, 0, 0, 0},
      // negative w hides the point
      '{wsp_pkg::OP_LOAD, 4'd15, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
        1, 1'b0, 40'sd0, 40'sd0, 32'sd0},
      '{wsp_pkg::OP_LOAD, 4'd15, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd12, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'shffff0000, 32'sd5, 32'sd0,
        0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd3, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd7, 32'shffff0000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd11, 32'sd1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sh123456, 32'shfedcba98, 32'sh40000,
        0, 0, 0, 0, 0},
      '{wsp_pkg::OP_LOAD, 4'd12, 32'sd0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{wsp_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0, 0, 0, 0, 0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      offer_item(row.op, row.idx, row.coef, row.wx, row.wy, row.wz);
      if (row.typed) begin
        typed_pt = '{row.vis, row.sx, row.sy, row.dz};
        pending_pts.push_back(typed_pt);
      end else begin
        account(row.op, row.idx, row.coef, row.wx, row.wy, row.wz);
      end
      input_gap();
    end

    // random phases, each with its own viewport setting
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      apb_write(ADDR_WIDTH, (ph == 6) ? 15'($urandom) : phase_w[ph]);
      apb_write(ADDR_HEIGHT, (ph == 6) ? 15'($urandom) : phase_h[ph]);
      if (ph == 2) hold_req = 1'b1;   // fill the block while the sender keeps going
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op = ($urandom_range(0, 9) < 7) ? wsp_pkg::OP_PROJECT : wsp_pkg::OP_LOAD;
        idx = 4'($urandom);
        cf = rand_coef();
        // keep w mostly positive so that the divide path sees real work
        if (op == wsp_pkg::OP_LOAD && idx == 4'd15 && $urandom_range(0, 3) != 0)
          cf = cf & 32'sh7fffffff;
        wx = rand_world();
        wy = rand_world();
        wz = rand_world();
        offer_item(op, idx, cf, wx, wy, wz);
        account(op, idx, cf, wx, wy, wz);
        if (ph == 4 && n == 100) begin
          // sender pauses until every pending point has come out
          in_valid_i <= 1'b0;
          while (pending_pts.size() != 0) @(posedge clk_i);
        end else if (ph != 2 || n > 120) begin
          input_gap();
        end
      end
    end

    drain();
    $display("ran %0d input transactions over 7 viewport settings incl. zero and maximum,",
             items_sent);
    $display("checked %0d projections, %0d of them not visible", points_seen, hidden_seen);
    if (mismatches == 0 && pending_pts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
